/* sv/assert_macros.svh */
// Assertion macros shared by the address translator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define MAT_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, including during reset.
`define MAT_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/mat_pkg.sv */
// Types and constants of the MAC address translator.
// Used by the controller, the datapath and the top level; depends on nothing.
package mat_pkg;

    localparam int ETH_W     = 48;
    localparam int LONG_W    = 64;
    localparam int TDATA_W   = 112;
    localparam int PREFIX_W  = 24;
    localparam int CNT_MAX_W = 6;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 64;

    localparam int          TR_BIT_POS  = 2;
    localparam logic [7:0]  PLAIN_B3    = 8'h02;
    localparam logic [7:0]  PLAIN_B4    = 8'h00;
    localparam logic [2:0]  XLAT_FLAGS  = 3'b110;

    localparam logic [1:0] RD_IDX  = 2'd0;
    localparam logic [1:0] RD_ZERO = 2'd1;
    localparam logic [1:0] RD_NEXT = 2'd2;

    localparam logic [2:0] RES_FAIL        = 3'd0;
    localparam logic [2:0] RES_OWN_LONG    = 3'd1;
    localparam logic [2:0] RES_DIRECT_LONG = 3'd2;
    localparam logic [2:0] RES_TABLE_LONG  = 3'd3;
    localparam logic [2:0] RES_OWN_ETH     = 3'd4;
    localparam logic [2:0] RES_COPY_ETH    = 3'd5;
    localparam logic [2:0] RES_HIT_ETH     = 3'd6;
    localparam logic [2:0] RES_ALLOC_ETH   = 3'd7;

    localparam logic REG_OWN_ETH  = 1'b0;
    localparam logic REG_OWN_LONG = 1'b1;

    typedef struct packed {
        logic       in_load;
        logic [1:0] rd_sel;
        logic       scan_clr;
        logic       scan_inc;
        logic       res_load;
        logic [2:0] res_sel;
        logic       alloc;
        logic       out_load;
    } mat_cmd_t;

    typedef struct packed {
        logic                 action;
        logic                 own_hit;
        logic                 tr_bit;
        logic                 idx_fail;
        logic                 plain;
        logic                 count_zero;
        logic                 key_match;
        logic                 scan_last;
        logic [CNT_MAX_W-1:0] count;
    } mat_status_t;

endpackage

/* sv/mat_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; holds the prefix table.
module mat_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/mat_regs.sv */
// APB register block holding the own Ethernet and own long addresses.
// Depends on mat_pkg for the port and address widths.
module mat_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mat_pkg::APB_AW-1:0] paddr,
    input  logic [mat_pkg::APB_DW-1:0] pwdata,
    output logic [mat_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output logic [mat_pkg::ETH_W-1:0]  own_eth,
    output logic [mat_pkg::LONG_W-1:0] own_long
);

    logic [mat_pkg::ETH_W-1:0]  own_eth_reg;
    logic [mat_pkg::ETH_W-1:0]  own_eth_next;
    logic [mat_pkg::LONG_W-1:0] own_long_reg;
    logic [mat_pkg::LONG_W-1:0] own_long_next;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        own_eth_next  = own_eth_reg;
        own_long_next = own_long_reg;
        if (wr_en) begin
            unique case (paddr[3])
                mat_pkg::REG_OWN_ETH:  own_eth_next  = pwdata[mat_pkg::ETH_W-1:0];
                mat_pkg::REG_OWN_LONG: own_long_next = pwdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_eth_reg  <= '0;
            own_long_reg <= '0;
        end else begin
            own_eth_reg  <= own_eth_next;
            own_long_reg <= own_long_next;
        end
    end

    always_comb begin
        unique case (paddr[3])
            mat_pkg::REG_OWN_ETH:  prdata = {16'h0000, own_eth_reg};
            mat_pkg::REG_OWN_LONG: prdata = own_long_reg;
        endcase
    end

    assign own_eth  = own_eth_reg;
    assign own_long = own_long_reg;

endmodule

/* sv/mat_ctrl.sv */
// Controller state machine of the MAC address translator.
// Depends on mat_pkg for the command and status structs and their codes.
module mat_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  mat_pkg::mat_status_t status,
    output mat_pkg::mat_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_TREAD  = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_ALLOC  = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = mat_pkg::RD_IDX;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.in_load = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!status.action) begin
                    if (status.own_hit) begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = mat_pkg::RES_OWN_LONG;
                        state_next   = ST_OUT;
                    end else if (status.tr_bit) begin
                        if (status.idx_fail) begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = mat_pkg::RES_FAIL;
                            state_next   = ST_OUT;
                        end else begin
                            cmd.rd_sel = mat_pkg::RD_IDX;
                            state_next = ST_TREAD;
                        end
                    end else begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = mat_pkg::RES_DIRECT_LONG;
                        state_next   = ST_OUT;
                    end
                end else begin
                    if (status.own_hit) begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = mat_pkg::RES_OWN_ETH;
                        state_next   = ST_OUT;
                    end else if (status.plain) begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = mat_pkg::RES_COPY_ETH;
                        state_next   = ST_OUT;
                    end else if (status.count_zero) begin
                        state_next = ST_ALLOC;
                    end else begin
                        cmd.rd_sel   = mat_pkg::RD_ZERO;
                        cmd.scan_clr = 1'b1;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_TREAD: begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = mat_pkg::RES_TABLE_LONG;
                state_next   = ST_OUT;
            end
            ST_SCAN: begin
                if (status.key_match) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = mat_pkg::RES_HIT_ETH;
                    state_next   = ST_OUT;
                end else if (status.scan_last) begin
                    state_next = ST_ALLOC;
                end else begin
                    cmd.rd_sel   = mat_pkg::RD_NEXT;
                    cmd.scan_inc = 1'b1;
                end
            end
            ST_ALLOC: begin
                cmd.alloc    = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_sel  = mat_pkg::RES_ALLOC_ETH;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

/* sv/mat_dp.sv */
// Datapath of the MAC address translator: input word, prefix table, scan and results.
// Depends on mat_pkg and instantiates mat_ram for the prefix table.
module mat_dp #(
    parameter int PREFIX_ENTRIES = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mat_pkg::mat_cmd_t           cmd,
    output mat_pkg::mat_status_t        status,
    input  logic                        in_action,
    input  logic [mat_pkg::ETH_W-1:0]   in_eth,
    input  logic [mat_pkg::LONG_W-1:0]  in_long,
    input  logic [mat_pkg::ETH_W-1:0]   own_eth,
    input  logic [mat_pkg::LONG_W-1:0]  own_long,
    output logic [mat_pkg::ETH_W-1:0]   out_eth,
    output logic [mat_pkg::LONG_W-1:0]  out_long,
    output logic                        out_ok
);

    localparam int IDX_W = (PREFIX_ENTRIES > 1) ? $clog2(PREFIX_ENTRIES) : 1;
    localparam int CNT_W = IDX_W + 1;

    logic                          action_reg;
    logic [mat_pkg::ETH_W-1:0]     eth_reg;
    logic [mat_pkg::LONG_W-1:0]    long_reg;
    logic [IDX_W-1:0]              scan_reg;
    logic [IDX_W-1:0]              scan_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [mat_pkg::ETH_W-1:0]     res_eth_reg;
    logic [mat_pkg::ETH_W-1:0]     res_eth_next;
    logic [mat_pkg::LONG_W-1:0]    res_long_reg;
    logic [mat_pkg::LONG_W-1:0]    res_long_next;
    logic                          res_ok_reg;
    logic                          res_ok_next;
    logic [mat_pkg::ETH_W-1:0]     out_eth_reg;
    logic [mat_pkg::LONG_W-1:0]    out_long_reg;
    logic                          out_ok_reg;

    logic [7:0]                    eb0;
    logic [4:0]                    eidx;
    logic [7:0]                    lb0;
    logic [7:0]                    lb3;
    logic [7:0]                    lb4;
    logic [15:0]                   lmid;
    logic [mat_pkg::PREFIX_W-1:0]  key;
    logic [IDX_W-1:0]              raddr;
    logic [mat_pkg::PREFIX_W-1:0]  rdata;
    logic                          full;
    logic [IDX_W-1:0]              alloc_idx;
    logic [IDX_W-1:0]              xlat_idx;

    assign eb0  = eth_reg[47:40];
    assign eidx = eb0[7:3];
    assign lb0  = long_reg[63:56];
    assign lb3  = long_reg[39:32];
    assign lb4  = long_reg[31:24];
    assign lmid = long_reg[55:40];
    assign key  = {lb0, lb3, lb4};

    assign full      = (count_reg == CNT_W'(PREFIX_ENTRIES));
    assign alloc_idx = full ? '0 : count_reg[IDX_W-1:0];
    assign xlat_idx  = cmd.alloc ? alloc_idx : scan_reg;

    always_comb begin
        unique case (cmd.rd_sel)
            mat_pkg::RD_IDX:  raddr = eidx[IDX_W-1:0];
            mat_pkg::RD_ZERO: raddr = '0;
            mat_pkg::RD_NEXT: raddr = scan_reg + 1'b1;
            default:          raddr = '0;
        endcase
    end

    mat_ram #(
        .WIDTH (mat_pkg::PREFIX_W),
        .DEPTH (PREFIX_ENTRIES),
        .AW    (IDX_W)
    ) u_table (
        .aclk  (aclk),
        .we    (cmd.alloc),
        .waddr (alloc_idx),
        .wdata (key),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        status.action     = action_reg;
        status.own_hit    = action_reg ? (long_reg == own_long) : (eth_reg == own_eth);
        status.tr_bit     = eb0[mat_pkg::TR_BIT_POS];
        status.idx_fail   = (mat_pkg::CNT_MAX_W'(eidx) >= mat_pkg::CNT_MAX_W'(count_reg));
        status.plain      = (lb3 == mat_pkg::PLAIN_B3) && (lb4 == mat_pkg::PLAIN_B4)
                            && !lb0[mat_pkg::TR_BIT_POS];
        status.count_zero = (count_reg == '0);
        status.key_match  = (rdata == key);
        status.scan_last  = ((CNT_W'(scan_reg) + 1'b1) == count_reg);
        status.count      = mat_pkg::CNT_MAX_W'(count_reg);
    end

    always_comb begin
        scan_next = scan_reg;
        if (cmd.scan_clr) begin
            scan_next = '0;
        end else if (cmd.scan_inc) begin
            scan_next = scan_reg + 1'b1;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.alloc && !full) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_comb begin
        res_eth_next  = res_eth_reg;
        res_long_next = res_long_reg;
        res_ok_next   = res_ok_reg;
        if (cmd.res_load) begin
            res_eth_next  = '0;
            res_long_next = '0;
            res_ok_next   = 1'b1;
            unique case (cmd.res_sel)
                mat_pkg::RES_FAIL: begin
                    res_ok_next = 1'b0;
                end
                mat_pkg::RES_OWN_LONG: begin
                    res_long_next = own_long;
                end
                mat_pkg::RES_DIRECT_LONG: begin
                    res_long_next = {eb0, eth_reg[39:24], mat_pkg::PLAIN_B3,
                                     mat_pkg::PLAIN_B4, eth_reg[23:0]};
                end
                mat_pkg::RES_TABLE_LONG: begin
                    res_long_next = {rdata[23:16], eth_reg[39:24], rdata[15:8],
                                     rdata[7:0], eth_reg[23:0]};
                end
                mat_pkg::RES_OWN_ETH: begin
                    res_eth_next = own_eth;
                end
                mat_pkg::RES_COPY_ETH: begin
                    res_eth_next = {lb0, lmid, long_reg[23:0]};
                end
                mat_pkg::RES_HIT_ETH, mat_pkg::RES_ALLOC_ETH: begin
                    res_eth_next = {5'(xlat_idx), mat_pkg::XLAT_FLAGS, lmid, long_reg[23:0]};
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            action_reg <= in_action;
            eth_reg    <= in_eth;
            long_reg   <= in_long;
        end
        scan_reg     <= scan_next;
        res_eth_reg  <= res_eth_next;
        res_long_reg <= res_long_next;
        res_ok_reg   <= res_ok_next;
        if (cmd.out_load) begin
            out_eth_reg  <= res_eth_reg;
            out_long_reg <= res_long_reg;
            out_ok_reg   <= res_ok_reg;
        end
    end

    assign out_eth  = out_eth_reg;
    assign out_long = out_long_reg;
    assign out_ok   = out_ok_reg;

endmodule

/* sv/mac_address_translator_top.sv */
// After acceptance a word passes the decode state, the table read state for an indexed
// Ethernet address or the scan and allocate states for a long address where needed, and
// the output state; a new word waits until then. The scan reads one table entry per cycle.
// The result register frees the input side while a finished word waits on m_tready.
// Reset (aresetn, synchronous, active low) clears the prefix count, the own addresses
// and the handshake state; table contents are left as they are and never read unwritten.
`include "assert_macros.svh"

module mac_address_translator_top #(
    parameter int PREFIX_ENTRIES = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // eth_addr [47:0], long_addr [111:48]
    input  logic [mat_pkg::TDATA_W-1:0] s_tdata,
    // action [0]
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // eth_result [47:0], long_result [111:48]
    output logic [mat_pkg::TDATA_W-1:0] m_tdata,
    // ok [0]
    output logic                        m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mat_pkg::APB_AW-1:0]  paddr,
    input  logic [mat_pkg::APB_DW-1:0]  pwdata,
    output logic [mat_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    mat_pkg::mat_cmd_t           cmd;
    mat_pkg::mat_status_t        status;
    logic [mat_pkg::ETH_W-1:0]   own_eth;
    logic [mat_pkg::LONG_W-1:0]  own_long;
    logic [mat_pkg::ETH_W-1:0]   out_eth;
    logic [mat_pkg::LONG_W-1:0]  out_long;

    mat_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .own_eth  (own_eth),
        .own_long (own_long)
    );

    mat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mat_dp #(
        .PREFIX_ENTRIES (PREFIX_ENTRIES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_action (s_tuser),
        .in_eth    (s_tdata[47:0]),
        .in_long   (s_tdata[111:48]),
        .own_eth   (own_eth),
        .own_long  (own_long),
        .out_eth   (out_eth),
        .out_long  (out_long),
        .out_ok    (m_tuser)
    );

    assign m_tdata = {out_long, out_eth};

    `MAT_ASSERT(a_busy_after_accept, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "input accepted while a word is in flight")
    `MAT_ASSERT(a_out_slot_free, aclk, aresetn, cmd.out_load |-> (!m_tvalid || m_tready), "result register overwritten before it was taken")
    `MAT_ASSERT(a_count_bound, aclk, aresetn, status.count <= mat_pkg::CNT_MAX_W'(PREFIX_ENTRIES), "prefix count exceeds table size")
    `MAT_ASSERT(a_alloc_case, aclk, aresetn, cmd.alloc |-> (status.action && !status.own_hit && !status.plain), "table allocation outside a long address lookup")

endmodule

/* test/mac_address_translator_top_tb.sv */
// Self-checking testbench for mac_address_translator_top: a directed table, then random words.
// It holds its own model of the prefix table and own addresses, and uses mat_pkg.
`timescale 1ns / 100ps

module mac_address_translator_top_tb;

    localparam int TBL_DEPTH = 32;
    localparam int POOL_N    = 12;
    localparam int PHASES    = 6;
    localparam int PHASE_LEN = 222;
    localparam int LONG_HOLD = 300;
    localparam int TAIL      = 40;
    localparam int LIMIT     = 400000;

    localparam logic ACT_E2L = 1'b0;
    localparam logic ACT_L2E = 1'b1;
    localparam bit   CHK     = 1'b1;
    localparam bit   PRED    = 1'b0;

    localparam logic [mat_pkg::APB_AW-1:0] OWN_ETH_ADDR  = {mat_pkg::REG_OWN_ETH, 3'b000};
    localparam logic [mat_pkg::APB_AW-1:0] OWN_LONG_ADDR = {mat_pkg::REG_OWN_LONG, 3'b000};

    typedef struct packed {
        logic        action;
        logic [47:0] eth;
        logic [63:0] lng;
    } xlat_req_t;

    typedef struct packed {
        logic [47:0] eth;
        logic [63:0] lng;
        logic        ok;
    } xlat_res_t;

    typedef enum logic {ROW_W, ROW_C} row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        logic        action;
        logic [47:0] eth;
        logic [63:0] lng;
        logic        typed;
        xlat_res_t   res;
    } dir_row_t;

    localparam xlat_res_t NO_RES = '0;
    localparam int DIR_N = 26;

    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{ROW_W, ACT_E2L, 48'h0, 64'hDEAD_BEEF_0000_0001, CHK, '{48'h0, 64'h0, 1'b1}},
        '{ROW_W, ACT_E2L, 48'h0400_0000_0000, 64'h0, CHK, '{48'h0, 64'h0, 1'b0}},
        '{ROW_W, ACT_E2L, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, CHK,
          '{48'h0, 64'h0, 1'b0}},
        '{ROW_W, ACT_L2E, 48'hFFFF_FFFF_FFFF, 64'h0, CHK, '{48'h0, 64'h0, 1'b1}},
        '{ROW_W, ACT_E2L, 48'h0011_2233_4455, 64'h0, CHK,
          '{48'h0, 64'h0011_2202_0033_4455, 1'b1}},
        '{ROW_W, ACT_L2E, 48'h0, 64'h0011_2202_0033_4455, CHK,
          '{48'h0011_2233_4455, 64'h0, 1'b1}},
        '{ROW_W, ACT_L2E, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF, PRED, NO_RES},
        '{ROW_W, ACT_E2L, 48'h06FF_FFFF_FFFF, 64'h0, PRED, NO_RES},
        '{ROW_W, ACT_L2E, 48'h0, 64'h04AA_BB02_00CC_DDEE, PRED, NO_RES},
        '{ROW_W, ACT_L2E, 48'h0, 64'h04AA_BB02_00CC_DDEE, PRED, NO_RES},
        '{ROW_W, ACT_E2L, 48'h0E12_3456_789A, 64'h0, PRED, NO_RES},
        '{ROW_W, ACT_L2E, 48'h0, 64'h5A00_0000_0000_0000, PRED, NO_RES},
        '{ROW_W, ACT_E2L, 48'h1612_3456_789A, 64'h0, PRED, NO_RES},
        '{ROW_W, ACT_E2L, 48'h1C00_0000_0000, 64'h0, PRED, NO_RES},
        '{ROW_W, ACT_E2L, 48'hFBFF_FFFF_FFFF, 64'h0, PRED, NO_RES},
        '{ROW_W, ACT_L2E, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF, PRED, NO_RES},
        '{ROW_C, ACT_E2L, 48'h0C12_3456_7890, 64'h5A00_0000_0000_0000, PRED, NO_RES},
        '{ROW_W, ACT_E2L, 48'h0C12_3456_7890, 64'h0, PRED, NO_RES},
        '{ROW_W, ACT_L2E, 48'h0, 64'h5A00_0000_0000_0000, PRED, NO_RES},
        '{ROW_W, ACT_E2L, 48'h0, 64'h0, PRED, NO_RES},
        '{ROW_C, ACT_E2L, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, PRED, NO_RES},
        '{ROW_W, ACT_E2L, 48'hFFFF_FFFF_FFFF, 64'h0, PRED, NO_RES},
        '{ROW_W, ACT_L2E, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF, PRED, NO_RES},
        '{ROW_W, ACT_L2E, 48'h0, 64'h0, PRED, NO_RES},
        '{ROW_C, ACT_E2L, 48'h0, 64'h0, PRED, NO_RES},
        '{ROW_W, ACT_E2L, 48'h1E00_0000_0001, 64'h0, PRED, NO_RES}
    };

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [mat_pkg::TDATA_W-1:0]  s_tdata;
    logic                         s_tuser;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [mat_pkg::TDATA_W-1:0]  m_tdata;
    logic                         m_tuser;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [mat_pkg::APB_AW-1:0]   paddr;
    logic [mat_pkg::APB_DW-1:0]   pwdata;
    logic [mat_pkg::APB_DW-1:0]   prdata;
    logic                         pready;

    logic [47:0] own_eth;
    logic [63:0] own_long;
    logic [23:0] prefix_tbl [TBL_DEPTH];
    int          prefix_cnt;
    logic [23:0] prefix_pool [POOL_N];

    xlat_res_t pending_res[$];
    int        mismatches = 0;
    int        cycles = 0;
    bit        quiet = 1'b0;
    bit        long_hold_req = 1'b0;

    always #2 aclk = ~aclk;

    mac_address_translator_top #(
        .PREFIX_ENTRIES(TBL_DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic xlat_res_t translate_addr(xlat_req_t w);
        xlat_res_t   r;
        logic [7:0]  b0;
        logic [7:0]  b3;
        logic [7:0]  b4;
        logic [23:0] ent;
        logic [23:0] key;
        int          idx;
        r.eth = '0;
        r.lng = '0;
        r.ok  = 1'b1;
        if (w.action == ACT_E2L) begin
            b0 = w.eth[47:40];
            if (w.eth == own_eth) begin
                r.lng = own_long;
            end else if (b0[mat_pkg::TR_BIT_POS]) begin
                idx = int'(b0[7:3]);
                if (idx >= prefix_cnt) begin
                    r.ok = 1'b0;
                end else begin
                    ent = prefix_tbl[idx];
                    r.lng = {ent[23:16], w.eth[39:24], ent[15:8], ent[7:0], w.eth[23:0]};
                end
            end else begin
                r.lng = {b0, w.eth[39:24], mat_pkg::PLAIN_B3, mat_pkg::PLAIN_B4,
                         w.eth[23:0]};
            end
        end else begin
            b0 = w.lng[63:56];
            b3 = w.lng[39:32];
            b4 = w.lng[31:24];
            if (w.lng == own_long) begin
                r.eth = own_eth;
            end else if (b3 == mat_pkg::PLAIN_B3 && b4 == mat_pkg::PLAIN_B4
                         && !b0[mat_pkg::TR_BIT_POS]) begin
                r.eth = {b0, w.lng[55:40], w.lng[23:0]};
            end else begin
                key = {b0, b3, b4};
                idx = 0;
                while (idx < prefix_cnt && prefix_tbl[idx] != key)
                    idx++;
                if (idx >= TBL_DEPTH) begin
                    idx = 0;
                    prefix_cnt = TBL_DEPTH;
                end else if (idx == prefix_cnt) begin
                    prefix_cnt++;
                end
                prefix_tbl[idx] = key;
                r.eth = {5'(idx), mat_pkg::XLAT_FLAGS, w.lng[55:40], w.lng[23:0]};
            end
        end
        return r;
    endfunction

    function automatic xlat_req_t random_word();
        xlat_req_t   w;
        logic [63:0] r;
        logic [23:0] pfx;
        int          sel;
        r = rnd64();
        w.eth = r[47:0];
        w.lng = rnd64();
        w.action = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 99);
        if (w.action == ACT_E2L) begin
            if (sel < 10) begin
                w.eth = own_eth;
            end else if (sel < 45 && prefix_cnt > 0) begin
                w.eth[47:43] = 5'($urandom_range(0, prefix_cnt - 1));
                w.eth[40+mat_pkg::TR_BIT_POS] = 1'b1;
            end else if (sel < 70) begin
                w.eth[40+mat_pkg::TR_BIT_POS] = 1'b1;
            end else begin
                w.eth[40+mat_pkg::TR_BIT_POS] = 1'b0;
            end
        end else begin
            if (sel < 10) begin
                w.lng = own_long;
            end else if (sel < 25) begin
                w.lng[39:24] = {mat_pkg::PLAIN_B3, mat_pkg::PLAIN_B4};
                w.lng[56+mat_pkg::TR_BIT_POS] = 1'b0;
            end else if (sel < 40) begin
                w.lng[56+mat_pkg::TR_BIT_POS] = 1'($urandom_range(0, 1));
            end else if (sel < 50) begin
                w.lng[39:24] = {mat_pkg::PLAIN_B3, mat_pkg::PLAIN_B4};
                w.lng[56+mat_pkg::TR_BIT_POS] = 1'b1;
            end else begin
                pfx = prefix_pool[$urandom_range(0, POOL_N - 1)];
                w.lng[63:56] = pfx[23:16];
                w.lng[39:24] = pfx[15:0];
            end
        end
        return w;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        mismatches++;
    endtask

    task automatic write_reg(logic [mat_pkg::APB_AW-1:0] addr,
                             logic [mat_pkg::APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_res.size() != 0);
    endtask

    task automatic set_own_addrs(logic [47:0] eth, logic [63:0] lng);
        drain_results();
        write_reg(OWN_ETH_ADDR, {16'h0, eth});
        write_reg(OWN_LONG_ADDR, lng);
        own_eth  = eth;
        own_long = lng;
    endtask

    task automatic idle_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic send_word(xlat_req_t w, bit typed, xlat_res_t typed_res);
        xlat_res_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= w.action;
        s_tdata  <= {w.lng, w.eth};
        do @(posedge aclk); while (!s_tready);
        r = translate_addr(w);
        pending_res.push_back(typed ? typed_res : r);
    endtask

    always @(posedge aclk) begin
        xlat_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_res.size() == 0) begin
                report_mismatch("unrequested word", {16'h0, m_tdata[47:0]}, '0);
            end else begin
                want = pending_res.pop_front();
                if (m_tdata[47:0] !== want.eth)
                    report_mismatch("eth_result", {16'h0, m_tdata[47:0]}, {16'h0, want.eth});
                if (m_tdata[111:48] !== want.lng)
                    report_mismatch("long_result", m_tdata[111:48], want.lng);
                if (m_tuser !== want.ok)
                    report_mismatch("ok", {63'h0, m_tuser}, {63'h0, want.ok});
            end
        end
    end

    initial begin : sink
        int unsigned stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0)
                stall_left--;
            else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end else if (!quiet && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 4);
            m_tready <= (stall_left == 0);
        end
    end

    initial begin : watchdog
        while (cycles < LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("mac_address_translator_top verification failed");
        $finish;
    end

    initial begin : stimulus
        logic [63:0] r;
        logic [47:0] cfg_eth;
        logic [63:0] cfg_long;
        logic [23:0] pfx;
        xlat_req_t   w;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        own_eth    = '0;
        own_long   = '0;
        prefix_cnt = 0;
        for (int i = 0; i < TBL_DEPTH; i++)
            prefix_tbl[i] = '0;
        for (int i = 0; i < POOL_N; i++)
            prefix_pool[i] = 24'($urandom());
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_N; i++) begin
            if (DIR_ROWS[i].kind == ROW_C) begin
                set_own_addrs(DIR_ROWS[i].eth, DIR_ROWS[i].lng);
            end else begin
                w.action = DIR_ROWS[i].action;
                w.eth    = DIR_ROWS[i].eth;
                w.lng    = DIR_ROWS[i].lng;
                idle_gap();
                send_word(w, DIR_ROWS[i].typed, DIR_ROWS[i].res);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            r = rnd64();
            cfg_eth  = r[47:0];
            cfg_long = rnd64();
            unique case (p)
                1, 5: begin
                    cfg_eth  = '0;
                    cfg_long = '0;
                end
                2: begin
                    cfg_eth  = '1;
                    cfg_long = '1;
                end
                3: begin
                    cfg_eth[40+mat_pkg::TR_BIT_POS] = 1'b1;
                    pfx = prefix_pool[$urandom_range(0, POOL_N - 1)];
                    cfg_long[63:56] = pfx[23:16];
                    cfg_long[39:24] = pfx[15:0];
                end
                default: ;
            endcase
            set_own_addrs(cfg_eth, cfg_long);
            quiet = (p == PHASES - 1);
            if (p == 2)
                long_hold_req = 1'b1;
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (p == 3 && n == PHASE_LEN / 2)
                    drain_results();
                idle_gap();
                send_word(random_word(), PRED, NO_RES);
            end
        end

        drain_results();
        repeat (TAIL) @(posedge aclk);
        if (mismatches == 0)
            $display("mac_address_translator_top verification clean");
        else
            $display("mac_address_translator_top verification failed");
        $finish;
    end

endmodule
